>>> rtl/zcl_pkg.sv
// Shared types, constants and command/status structs for the zero-crossing limiter.
// No dependencies; used by zcl_ctrl, zcl_dp and the top level.
package zcl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 1;
  localparam int MAX_DELAY   = 65536;
  localparam int ADDR_W      = $clog2(MAX_DELAY);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int RF_W        = 31;
  localparam int RF_SHIFT    = 30;
  localparam int MK_W        = 20;
  localparam int MK_SHIFT    = 16;
  localparam int DIV_STEPS   = FRAC;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FRAC-1:0]               mag_t;
  typedef logic [FRAC:0]                 gain_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [LEN_W-1:0]              len_t;

  localparam gain_t GAIN_ONE = {1'b1, {FRAC{1'b0}}};
  localparam mag_t  MAG_MAX  = {FRAC{1'b1}};
  localparam len_t  LEN_MIN  = len_t'(2);
  localparam len_t  LEN_MAX  = len_t'(MAX_DELAY);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_RECOVERY  = 3'd1,
    REG_RELEASE   = 3'd2,
    REG_MAKEUP    = 3'd3,
    REG_CEILING   = 3'd4,
    REG_DELAY     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    mag_t             threshold;
    logic [RF_W-1:0]  recovery;
    logic             release_en;
    logic [MK_W-1:0]  makeup;
    mag_t             ceiling;
    len_t             len;
  } cfg_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic ch;
    logic write_in;
    logic div_init;
    logic div_step;
    logic seg_set;
    logic rd;
    logic mul;
    logic wr;
    logic rec_mul;
    logic rec_set;
    logic out_rd;
    logic out_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic crossing;
    logic last_entry;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/zero_crossing_lookahead_limiter_core.sv
// With no zero crossing a frame passes both channel writes and checks, the recovery update
// and the output read, multiply and load; a new frame is taken only after the result loads
// (ST_OUT waits for a free output register). Each channel that crosses zero adds a divide and a
// read, multiply, write pass over the N entries of the ended segment (N at most the delay length).
// Reset is synchronous: rst starts a sweep that zeroes all 65536 entries of both delay stores,
// holding s_axis_tready low; configuration writes are taken throughout. Uses zcl_pkg/ctrl/dp.
module zero_crossing_lookahead_limiter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*zcl_pkg::SAMPLE_BITS-1:0] s_axis_tdata,  // left_in, right_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*zcl_pkg::SAMPLE_BITS-1:0] m_axis_tdata,  // left_out, right_out
  input  logic                              cfg_we,
  input  logic [zcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zcl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SB = zcl_pkg::SAMPLE_BITS;

  zcl_pkg::cmd_t cmd;
  zcl_pkg::sts_t sts;
  zcl_pkg::cfg_t cfg;
  zcl_pkg::sample_t left_out, right_out;

  // configuration registers, raw as written
  zcl_pkg::mag_t                 threshold, ceiling;
  logic [zcl_pkg::RF_W-1:0]      recovery_factor;
  logic                          release_enable;
  logic [zcl_pkg::MK_W-1:0]      makeup_gain;
  zcl_pkg::len_t                 delay_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= zcl_pkg::MAG_MAX;
      recovery_factor <= zcl_pkg::RF_W'(1) << zcl_pkg::RF_SHIFT;
      release_enable  <= 1'b0;
      makeup_gain     <= zcl_pkg::MK_W'(1) << zcl_pkg::MK_SHIFT;
      ceiling         <= zcl_pkg::MAG_MAX;
      delay_length    <= zcl_pkg::len_t'(48000);
    end else if (cfg_we) begin
      case (zcl_pkg::cfg_reg_t'(cfg_index))
        zcl_pkg::REG_THRESHOLD: threshold       <= cfg_data[zcl_pkg::FRAC-1:0];
        zcl_pkg::REG_RECOVERY:  recovery_factor <= cfg_data[zcl_pkg::RF_W-1:0];
        zcl_pkg::REG_RELEASE:   release_enable  <= cfg_data[0];
        zcl_pkg::REG_MAKEUP:    makeup_gain     <= cfg_data[zcl_pkg::MK_W-1:0];
        zcl_pkg::REG_CEILING:   ceiling         <= cfg_data[zcl_pkg::FRAC-1:0];
        zcl_pkg::REG_DELAY:     delay_length    <= cfg_data[zcl_pkg::LEN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // clamp the store length into its usable range
  always_comb begin
    cfg.threshold  = threshold;
    cfg.recovery   = recovery_factor;
    cfg.release_en = release_enable;
    cfg.makeup     = makeup_gain;
    cfg.ceiling    = ceiling;
    if (delay_length < zcl_pkg::LEN_MIN)      cfg.len = zcl_pkg::LEN_MIN;
    else if (delay_length > zcl_pkg::LEN_MAX) cfg.len = zcl_pkg::LEN_MAX;
    else                                      cfg.len = delay_length;
  end

  zcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  zcl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .left_in   (s_axis_tdata[SB-1:0]),
    .right_in  (s_axis_tdata[2*SB-1:SB]),
    .left_out  (left_out),
    .right_out (right_out),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {right_out, left_out};

  // one frame in flight: an accepted transaction closes the input until done
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a frame is in progress");

  // the clear sweep holds off input after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during store clear");

  // a result loads only when the output register is free
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output overwritten before transaction");

endmodule

>>> rtl/zcl_ctrl.sv
// Sequencing state machine for the zero-crossing limiter.
// Depends on zcl_pkg; drives zcl_dp through cmd_t and watches sts_t.
module zcl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  zcl_pkg::sts_t sts,
  output zcl_pkg::cmd_t cmd
);

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_WRITE  = 15'b000000000000100,
    ST_CHECK  = 15'b000000000001000,
    ST_DIV    = 15'b000000000010000,
    ST_SEG    = 15'b000000000100000,
    ST_RD     = 15'b000000001000000,
    ST_MUL    = 15'b000000010000000,
    ST_WR     = 15'b000000100000000,
    ST_REC    = 15'b000001000000000,
    ST_RECSET = 15'b000010000000000,
    ST_ORD    = 15'b000100000000000,
    ST_OMUL   = 15'b001000000000000,
    ST_OUT    = 15'b010000000000000,
    ST_SPARE  = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic ch, ch_next;
  logic [zcl_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.ch       = ch;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          ch_next    = 1'b0;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_in = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.crossing) begin
          cmd.div_init = 1'b1;
          div_cnt_next = '0;
          state_next   = ST_DIV;
        end else if (ch) begin
          state_next = ST_REC;
        end else begin
          ch_next    = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == zcl_pkg::DIV_CNT_W'(zcl_pkg::DIV_STEPS - 1)) state_next = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg_set = 1'b1;
        state_next  = ST_RD;
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (!sts.last_entry) begin
          state_next = ST_RD;
        end else if (ch) begin
          state_next = ST_REC;
        end else begin
          ch_next    = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_REC: begin
        cmd.rec_mul = 1'b1;
        state_next  = ST_RECSET;
      end
      ST_RECSET: begin
        cmd.rec_set = 1'b1;
        state_next  = ST_ORD;
      end
      ST_ORD: begin
        cmd.out_rd = 1'b1;
        state_next = ST_OMUL;
      end
      ST_OMUL: begin
        cmd.out_mul = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      ch      <= 1'b0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      ch      <= ch_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

>>> rtl/zcl_dp.sv
// Datapath of the zero-crossing limiter: delay stores, per-channel state,
// divider, multipliers and output register. Depends on zcl_pkg.
module zcl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  zcl_pkg::cmd_t                 cmd,
  output zcl_pkg::sts_t                 sts,
  input  zcl_pkg::cfg_t                 cfg,
  input  zcl_pkg::sample_t              left_in,
  input  zcl_pkg::sample_t              right_in,
  output zcl_pkg::sample_t              left_out,
  output zcl_pkg::sample_t              right_out,
  output logic                          out_valid,
  input  logic                          out_ready
);

  localparam int SB = zcl_pkg::SAMPLE_BITS;
  localparam int FR = zcl_pkg::FRAC;

  // delay stores
  zcl_pkg::sample_t mem_l [zcl_pkg::MAX_DELAY];
  zcl_pkg::sample_t mem_r [zcl_pkg::MAX_DELAY];
  zcl_pkg::sample_t rdat_l, rdat_r;

  zcl_pkg::addr_t clr_cnt, wp, idx;
  zcl_pkg::sample_t x_l, x_r;
  zcl_pkg::gain_t gain [2];
  zcl_pkg::mag_t  peak [2];
  zcl_pkg::len_t  seglen [2];
  logic           lastpos [2];
  logic           crossing;
  zcl_pkg::len_t  remaining;
  zcl_pkg::mag_t  rem, quo;
  logic [2*SB-1:0] prod;
  logic            prod_neg;
  logic [SB+zcl_pkg::RF_W-1:0] rp [2];
  logic [SB+zcl_pkg::MK_W-1:0] op_l, op_r;
  logic            oneg_l, oneg_r;

  // write-side mux
  zcl_pkg::sample_t x_c, scaled, wdata_l, wdata_r, rsrc;
  zcl_pkg::addr_t   waddr, raddr;
  logic             we_l, we_r;
  logic [SB-1:0]    m_raw, rmag;
  zcl_pkg::mag_t    m_sat, pk_n;
  logic             pos;
  logic [SB:0]      r2;
  logic [2*SB:0]    prod_rnd;
  logic [SB-1:0]    smag;
  zcl_pkg::gain_t   seg;
  logic [zcl_pkg::LEN_W:0] seg_inc, cnt_c;

  assign x_c   = cmd.ch ? x_r : x_l;
  assign m_raw = x_c[SB-1] ? SB'(-x_c) : SB'(x_c);
  assign m_sat = (m_raw > SB'(zcl_pkg::MAG_MAX)) ? zcl_pkg::MAG_MAX : m_raw[FR-1:0];
  assign pk_n  = (m_sat > peak[cmd.ch]) ? m_sat : peak[cmd.ch];
  assign pos   = !x_c[SB-1] && (x_c != '0);
  assign seg_inc = {1'b0, seglen[cmd.ch]} + 1'b1;
  assign cnt_c   = (seg_inc > {1'b0, cfg.len}) ? {1'b0, cfg.len} : seg_inc;

  assign prod_rnd = {1'b0, prod} + (2*SB+1)'(1 << (FR - 1));
  assign smag     = prod_rnd[FR+SB-1:FR];
  assign scaled   = prod_neg ? zcl_pkg::sample_t'(-smag) : zcl_pkg::sample_t'(smag);

  assign rsrc = cmd.ch ? rdat_r : rdat_l;
  assign rmag = rsrc[SB-1] ? SB'(-rsrc) : SB'(rsrc);

  assign r2  = {1'b0, rem, 1'b0};
  assign seg = (peak[cmd.ch] > cfg.threshold) ? {1'b0, quo} : zcl_pkg::GAIN_ONE;

  assign waddr = cmd.clear_step ? clr_cnt : (cmd.write_in ? wp : idx);
  assign raddr = cmd.out_rd ? wp : idx;
  assign we_l  = cmd.clear_step || ((cmd.write_in || cmd.wr) && !cmd.ch);
  assign we_r  = cmd.clear_step || ((cmd.write_in || cmd.wr) && cmd.ch);
  assign wdata_l = cmd.clear_step ? '0 : (cmd.write_in ? x_l : scaled);
  assign wdata_r = cmd.clear_step ? '0 : (cmd.write_in ? x_r : scaled);

  always_ff @(posedge clk) begin
    if (we_l) mem_l[waddr] <= wdata_l;
    if (cmd.out_rd || (cmd.rd && !cmd.ch)) rdat_l <= mem_l[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_r) mem_r[waddr] <= wdata_r;
    if (cmd.out_rd || (cmd.rd && cmd.ch)) rdat_r <= mem_r[raddr];
  end

  // output rounding and clip
  logic [SB+zcl_pkg::MK_W:0] orl, orr;
  logic [SB+zcl_pkg::MK_W-zcl_pkg::MK_SHIFT:0] oml, omr;
  zcl_pkg::mag_t cl_l, cl_r;
  assign orl  = {1'b0, op_l} + (SB+zcl_pkg::MK_W+1)'(1 << (zcl_pkg::MK_SHIFT - 1));
  assign orr  = {1'b0, op_r} + (SB+zcl_pkg::MK_W+1)'(1 << (zcl_pkg::MK_SHIFT - 1));
  assign oml  = orl[SB+zcl_pkg::MK_W:zcl_pkg::MK_SHIFT];
  assign omr  = orr[SB+zcl_pkg::MK_W:zcl_pkg::MK_SHIFT];
  assign cl_l = (oml > $bits(oml)'(cfg.ceiling)) ? cfg.ceiling : oml[FR-1:0];
  assign cl_r = (omr > $bits(omr)'(cfg.ceiling)) ? cfg.ceiling : omr[FR-1:0];

  // recovery: floor(gain * factor / 2^30), capped at one; one when release is disabled
  logic [SB+zcl_pkg::RF_W-zcl_pkg::RF_SHIFT-1:0] rn [2];
  zcl_pkg::gain_t rg [2];
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      rn[c] = rp[c][SB+zcl_pkg::RF_W-1:zcl_pkg::RF_SHIFT];
      if (!cfg.release_en || rn[c] > $bits(rn[c])'(zcl_pkg::GAIN_ONE)) rg[c] = zcl_pkg::GAIN_ONE;
      else rg[c] = rn[c][FR:0];
    end
  end

  logic [zcl_pkg::ADDR_W:0] wp_inc;
  assign wp_inc = {1'b0, wp} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
      crossing  <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        gain[c]    <= zcl_pkg::GAIN_ONE;
        peak[c]    <= '0;
        seglen[c]  <= '0;
        lastpos[c] <= 1'b0;
      end
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.load) begin
        x_l <= left_in;
        x_r <= right_in;
        if ({1'b0, wp} >= cfg.len) wp <= '0;
      end
      if (cmd.write_in) begin
        crossing        <= (pos != lastpos[cmd.ch]);
        lastpos[cmd.ch] <= pos;
        idx             <= wp;
        remaining       <= cnt_c[zcl_pkg::LEN_W-1:0];
        if (pos != lastpos[cmd.ch]) begin
          peak[cmd.ch] <= pk_n;
        end else if (seg_inc >= {1'b0, cfg.len}) begin
          seglen[cmd.ch] <= '0;
          peak[cmd.ch]   <= '0;
        end else begin
          seglen[cmd.ch] <= seg_inc[zcl_pkg::LEN_W-1:0];
          peak[cmd.ch]   <= pk_n;
        end
      end
      if (cmd.div_init) begin
        rem <= cfg.threshold;
        quo <= '0;
      end
      if (cmd.div_step) begin
        // one restoring step; remainder stays below the peak when the threshold is below it
        if (r2 >= {1'b0, 1'b0, peak[cmd.ch]}) begin
          rem <= FR'(r2 - {1'b0, 1'b0, peak[cmd.ch]});
          quo <= {quo[FR-2:0], 1'b1};
        end else begin
          rem <= r2[FR-1:0];
          quo <= {quo[FR-2:0], 1'b0};
        end
      end
      if (cmd.seg_set) begin
        if (seg < gain[cmd.ch]) gain[cmd.ch] <= seg;
        seglen[cmd.ch] <= '0;
        peak[cmd.ch]   <= '0;
      end
      if (cmd.mul) begin
        prod     <= rmag * SB'(gain[cmd.ch]);
        prod_neg <= rsrc[SB-1];
      end
      if (cmd.wr) begin
        remaining <= remaining - 1'b1;
        idx       <= (idx == '0) ? zcl_pkg::ADDR_W'(cfg.len - 1'b1) : idx - 1'b1;
      end
      if (cmd.rec_mul) begin
        rp[0] <= gain[0] * cfg.recovery;
        rp[1] <= gain[1] * cfg.recovery;
      end
      if (cmd.rec_set) begin
        gain[0] <= rg[0];
        gain[1] <= rg[1];
        wp      <= (wp_inc >= cfg.len) ? '0 : wp_inc[zcl_pkg::ADDR_W-1:0];
      end
      if (cmd.out_mul) begin
        op_l   <= (rdat_l[SB-1] ? SB'(-rdat_l) : SB'(rdat_l)) * cfg.makeup;
        op_r   <= (rdat_r[SB-1] ? SB'(-rdat_r) : SB'(rdat_r)) * cfg.makeup;
        oneg_l <= rdat_l[SB-1];
        oneg_r <= rdat_r[SB-1];
      end
      if (cmd.out_load) begin
        left_out  <= oneg_l ? zcl_pkg::sample_t'(-{1'b0, cl_l}) : zcl_pkg::sample_t'({1'b0, cl_l});
        right_out <= oneg_r ? zcl_pkg::sample_t'(-{1'b0, cl_r}) : zcl_pkg::sample_t'({1'b0, cl_r});
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.clear_last = (clr_cnt == {zcl_pkg::ADDR_W{1'b1}});
  assign sts.crossing   = crossing;
  assign sts.last_entry = (remaining == zcl_pkg::len_t'(1));
  assign sts.out_free   = !out_valid || out_ready;

endmodule
